FILE: rtl/core/scd_pkg.sv
// Package for the scrambled card draw block: constants and helper functions.
// Depends on nothing; used by every module under rtl/core.
`default_nettype none

package scd_pkg;

    localparam int SCD_MAX_DRAW  = 5;
    localparam int SCD_DECK_SIZE = 52;
    localparam int SCD_MASK_W    = 52;
    localparam int SCD_COUNT_W   = 3;
    localparam int SCD_SEQ_W     = 64;
    localparam int SCD_MAX_COUNT = (1 << SCD_COUNT_W) - 1;

    localparam logic [31:0] GOLDEN_MUL  = 32'h9E37_79B9;
    localparam logic [31:0] INDEX_MUL   = 32'h85EB_CA6B;
    localparam logic [63:0] DRAW_STRIDE = 64'd1315423911;

    function automatic logic [31:0] bit_rev32(input logic [31:0] v);
        logic [31:0] r;
        for (int i = 0; i < 32; i++) begin
            r[i] = v[31 - i];
        end
        return r;
    endfunction

    // Low word of j * stride for draw j.
    function automatic logic [31:0] stride_lo(input int unsigned j);
        logic [63:0] p;
        p = 64'(j) * DRAW_STRIDE;
        return p[31:0];
    endfunction

    // Low word of golden ratio constant times (j + 1).
    function automatic logic [31:0] golden_at(input int unsigned j);
        logic [63:0] p;
        p = 64'(j + 1) * 64'(GOLDEN_MUL);
        return p[31:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/scd_propose.sv
// Two-stage front end: index scramble and per-draw sequence words, then
// bit reversal, scramble and scaling to a proposed card. Uses scd_pkg.
`default_nettype none

module scd_propose
    import scd_pkg::*;
#(
    parameter int NDRAW     = SCD_MAX_DRAW,
    parameter int DECK_SIZE = SCD_DECK_SIZE,
    parameter int CARD_W    = $clog2(DECK_SIZE)
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [DECK_SIZE-1:0]              used,
    input  wire logic [SCD_COUNT_W-1:0]            cnt,
    input  wire logic [31:0]                       seq_lo,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [DECK_SIZE-1:0]                   used_out,
    output logic [SCD_COUNT_W-1:0]                 cnt_out,
    output logic [NDRAW-1:0][CARD_W-1:0]           cards
);

    localparam int PROD_W = 32 + $clog2(DECK_SIZE + 1);

    logic                          s1_valid_reg;
    logic                          s1_ready;
    logic [31:0]                   s1_scr_reg;
    logic [NDRAW-1:0][31:0]        s1_n_reg;
    logic [DECK_SIZE-1:0]          s1_used_reg;
    logic [SCD_COUNT_W-1:0]        s1_cnt_reg;

    logic                          s2_valid_reg;
    logic [NDRAW-1:0][CARD_W-1:0]  s2_card_reg;
    logic [NDRAW-1:0][CARD_W-1:0]  s2_card_next;
    logic [DECK_SIZE-1:0]          s2_used_reg;
    logic [SCD_COUNT_W-1:0]        s2_cnt_reg;

    logic [NDRAW-1:0][31:0]        n_next;
    logic [31:0]                   scr_next;

    assign s1_ready = !s2_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_ready;

    always_comb
    begin
        scr_next = seq_lo * INDEX_MUL;
        for (int j = 0; j < NDRAW; j++) begin
            n_next[j] = seq_lo + stride_lo(j);
        end
    end

    always_comb
    begin
        logic [31:0]       rev;
        logic [PROD_W-1:0] prod;
        for (int j = 0; j < NDRAW; j++) begin
            rev  = bit_rev32(s1_n_reg[j]) ^ golden_at(j) ^ s1_scr_reg;
            prod = PROD_W'(rev) * PROD_W'(DECK_SIZE);
            s2_card_next[j] = prod[32 +: CARD_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else begin
            if (in_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s1_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            s1_scr_reg  <= scr_next;
            s1_n_reg    <= n_next;
            s1_used_reg <= used;
            s1_cnt_reg  <= cnt;
        end
        if (s1_ready && s1_valid_reg) begin
            s2_card_reg <= s2_card_next;
            s2_used_reg <= s1_used_reg;
            s2_cnt_reg  <= s1_cnt_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign used_out  = s2_used_reg;
    assign cnt_out   = s2_cnt_reg;
    assign cards     = s2_card_reg;

endmodule

`default_nettype wire

FILE: rtl/core/scd_draw_stage.sv
// One draw: cyclic search upward from the proposed card for the first free card,
// then mark it drawn if J is below the count. One register stage. Uses scd_pkg.
`default_nettype none

module scd_draw_stage
    import scd_pkg::*;
#(
    parameter int J         = 0,
    parameter int NDRAW     = SCD_MAX_DRAW,
    parameter int DECK_SIZE = SCD_DECK_SIZE,
    parameter int CARD_W    = $clog2(DECK_SIZE)
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [DECK_SIZE-1:0]              used,
    input  wire logic [DECK_SIZE-1:0]              board,
    input  wire logic [SCD_COUNT_W-1:0]            cnt,
    input  wire logic [NDRAW-1:0][CARD_W-1:0]      cards,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [DECK_SIZE-1:0]                   used_out,
    output logic [DECK_SIZE-1:0]                   board_out,
    output logic [SCD_COUNT_W-1:0]                 cnt_out,
    output logic [NDRAW-1:0][CARD_W-1:0]           cards_out
);

    logic                          valid_reg;
    logic [DECK_SIZE-1:0]          used_reg;
    logic [DECK_SIZE-1:0]          used_next;
    logic [DECK_SIZE-1:0]          board_reg;
    logic [DECK_SIZE-1:0]          board_next;
    logic [SCD_COUNT_W-1:0]        cnt_reg;
    logic [NDRAW-1:0][CARD_W-1:0]  cards_reg;

    logic [DECK_SIZE-1:0]          free;
    logic [DECK_SIZE-1:0]          upper;
    logic [DECK_SIZE-1:0]          pick;
    logic                          active;

    assign in_ready = !valid_reg || out_ready;
    assign active   = SCD_COUNT_W'(J) < cnt;

    // Free cards at or above the proposal win; otherwise wrap to the lowest.
    always_comb
    begin
        free  = ~used;
        upper = free & ({DECK_SIZE{1'b1}} << cards[J]);
        if (upper != '0) begin
            pick = upper & (~upper + 1'b1);
        end
        else begin
            pick = free & (~free + 1'b1);
        end
        if (active) begin
            used_next  = used | pick;
            board_next = board | pick;
        end
        else begin
            used_next  = used;
            board_next = board;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            used_reg  <= used_next;
            board_reg <= board_next;
            cnt_reg   <= cnt;
            cards_reg <= cards;
        end
    end

    assign out_valid = valid_reg;
    assign used_out  = used_reg;
    assign board_out = board_reg;
    assign cnt_out   = cnt_reg;
    assign cards_out = cards_reg;

    a_board_in_used: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((board_reg & ~used_reg) == '0))
        else $error("drawn card not marked used");

    a_board_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ($countones(board_reg) <= int'(cnt_reg)))
        else $error("more cards drawn than requested");

    a_board_le_stage: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ($countones(board_reg) <= J + 1))
        else $error("more cards drawn than stages passed");

endmodule

`default_nettype wire

FILE: rtl/core/scrambled_sobol_card_draw.sv
// Throughput is one transaction per clock; two front-end stages form the
// scrambled proposals for all draws at once, then one register stage per
// draw resolves its card against the cards taken so far, for up to MAX_DRAW
// draws (capped at 7, the most a 3-bit count can ask for).
// Backpressure stalls the whole pipeline in place; bubbles are squeezed out.
// Top level; uses scd_pkg, scd_propose and scd_draw_stage.
`default_nettype none

module scrambled_sobol_card_draw
    import scd_pkg::*;
#(
    parameter int MAX_DRAW  = SCD_MAX_DRAW,
    parameter int DECK_SIZE = SCD_DECK_SIZE
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [SCD_MASK_W-1:0]     dead_mask,
    input  wire logic [SCD_COUNT_W-1:0]    draw_count,
    input  wire logic [SCD_SEQ_W-1:0]      sequence_index,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [SCD_MASK_W-1:0]          board_mask
);

    localparam int NDRAW  = (MAX_DRAW < SCD_MAX_COUNT) ? MAX_DRAW : SCD_MAX_COUNT;
    localparam int CARD_W = $clog2(DECK_SIZE);
    localparam logic [SCD_COUNT_W-1:0] CNT_CAP = SCD_COUNT_W'(NDRAW);

    logic [DECK_SIZE-1:0]          used_in;
    logic [SCD_COUNT_W-1:0]        cnt_in;

    logic [NDRAW:0]                v_c;
    logic [NDRAW:0]                r_c;
    logic [DECK_SIZE-1:0]          used_c  [NDRAW+1];
    logic [DECK_SIZE-1:0]          board_c [NDRAW+1];
    logic [SCD_COUNT_W-1:0]        cnt_c   [NDRAW+1];
    logic [NDRAW-1:0][CARD_W-1:0]  cards_c [NDRAW];

    // Drop dead bits outside the deck; saturate the draw count.
    always_comb
    begin
        for (int c = 0; c < DECK_SIZE; c++) begin
            used_in[c] = (c < SCD_MASK_W) ? dead_mask[c % SCD_MASK_W] : 1'b0;
        end
        cnt_in = (draw_count > CNT_CAP) ? CNT_CAP : draw_count;
    end

    scd_propose #(
        .NDRAW     (NDRAW),
        .DECK_SIZE (DECK_SIZE),
        .CARD_W    (CARD_W)
    ) u_propose (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .used      (used_in),
        .cnt       (cnt_in),
        .seq_lo    (sequence_index[31:0]),
        .out_valid (v_c[0]),
        .out_ready (r_c[0]),
        .used_out  (used_c[0]),
        .cnt_out   (cnt_c[0]),
        .cards     (cards_c[0])
    );

    assign board_c[0] = '0;

    for (genvar j = 0; j < NDRAW; j++) begin : g_draw
        if (j < NDRAW - 1) begin : g_mid
            scd_draw_stage #(
                .J         (j),
                .NDRAW     (NDRAW),
                .DECK_SIZE (DECK_SIZE),
                .CARD_W    (CARD_W)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (v_c[j]),
                .in_ready  (r_c[j]),
                .used      (used_c[j]),
                .board     (board_c[j]),
                .cnt       (cnt_c[j]),
                .cards     (cards_c[j]),
                .out_valid (v_c[j+1]),
                .out_ready (r_c[j+1]),
                .used_out  (used_c[j+1]),
                .board_out (board_c[j+1]),
                .cnt_out   (cnt_c[j+1]),
                .cards_out (cards_c[j+1])
            );
        end
        else begin : g_last
            scd_draw_stage #(
                .J         (j),
                .NDRAW     (NDRAW),
                .DECK_SIZE (DECK_SIZE),
                .CARD_W    (CARD_W)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (v_c[j]),
                .in_ready  (r_c[j]),
                .used      (used_c[j]),
                .board     (board_c[j]),
                .cnt       (cnt_c[j]),
                .cards     (cards_c[j]),
                .out_valid (v_c[j+1]),
                .out_ready (r_c[j+1]),
                .used_out  (used_c[j+1]),
                .board_out (board_c[j+1]),
                .cnt_out   (cnt_c[j+1]),
                .cards_out ()
            );
        end
    end

    assign out_valid     = v_c[NDRAW];
    assign r_c[NDRAW]    = out_ready;

    always_comb
    begin
        for (int c = 0; c < SCD_MASK_W; c++) begin
            board_mask[c] = (c < DECK_SIZE) ? board_c[NDRAW][c % DECK_SIZE] : 1'b0;
        end
    end

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with an empty output stage");

    a_out_in_deck_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((board_c[NDRAW] & ~used_c[NDRAW]) == '0))
        else $error("output card not marked used");

    a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($countones(board_c[NDRAW]) <= int'(cnt_c[NDRAW])))
        else $error("output holds more cards than requested");

endmodule

`default_nettype wire
